[rtl/core/sjn_pkg.sv]
// ----------------------------------------------------------------------------
// sjn_pkg
// Shared constants, payload types and controller/datapath link types for the
// shortest-job-next scheduler.
// ----------------------------------------------------------------------------
package sjn_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int LENGTH_BITS = 16;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + LENGTH_BITS;

    // one scheduler tick
    typedef struct packed {
        logic                   arrival_valid;
        logic [ID_BITS-1:0]     task_id;
        logic [LENGTH_BITS-1:0] task_length;
    } t_in;

    // one tick result
    typedef struct packed {
        logic               running_valid;
        logic [ID_BITS-1:0] running_id;
        logic               picked_now;
        logic               arrival_dropped;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan_init;
        logic scan_rd;
        logic pick;
        logic shift_rd;
        logic run;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_pick;
        logic scan_last;
        logic shift_more;
    } t_sts;

endpackage

[rtl/core/sjn_ram.sv]
// ----------------------------------------------------------------------------
// sjn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sjn_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/sjn_dp.sv]
// ----------------------------------------------------------------------------
// sjn_dp
// Scheduler datapath: waiting queue in RAM, running task, minimum scan,
// queue compaction and the result register.
// ----------------------------------------------------------------------------
module sjn_dp
    import sjn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_result,
    output logic o_valid
);

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_addr;
    logic                   r_rd_vld;
    logic                   r_rd_shift;
    logic [CNT_W-1:0]       r_rd_idx;
    logic                   r_best_ok;
    logic [CNT_W-1:0]       r_best_idx;
    logic [ID_BITS-1:0]     r_best_id;
    logic [LENGTH_BITS-1:0] r_best_len;
    logic                   r_task_busy;
    logic [ID_BITS-1:0]     r_cur_id;
    logic [LENGTH_BITS-1:0] r_remain;
    logic                   r_picked;
    logic                   r_dropped;
    t_out                   r_out;
    logic                   r_out_vld;

    logic                   full;
    logic [LENGTH_BITS-1:0] arr_len;
    logic                   arr_wr;
    logic                   shift_wr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   rd_en;
    logic [ENTRY_W-1:0]     rd_data;
    logic [ID_BITS-1:0]     rd_id;
    logic [LENGTH_BITS-1:0] rd_len;
    logic [CNT_W-1:0]       shift_dst;

    // arrival write and compaction write share the single write port
    assign full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign arr_len   = (i_item.task_length == '0) ? LENGTH_BITS'(1) : i_item.task_length;
    assign arr_wr    = i_cmd.accept && i_item.arrival_valid && !full;
    assign shift_wr  = r_rd_vld && r_rd_shift;
    assign shift_dst = r_rd_idx - CNT_W'(1);
    assign wr_en     = arr_wr || shift_wr;
    assign wr_addr   = shift_wr ? shift_dst[IDX_W-1:0] : r_count[IDX_W-1:0];
    assign wr_data   = shift_wr ? rd_data : {i_item.task_id, arr_len};

    assign rd_en  = i_cmd.scan_rd || i_cmd.shift_rd;
    assign rd_id  = rd_data[ENTRY_W-1:LENGTH_BITS];
    assign rd_len = rd_data[LENGTH_BITS-1:0];

    sjn_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // status back to the controller
    assign o_sts.need_pick  = !r_task_busy && (r_count != '0);
    assign o_sts.scan_last  = ((r_addr + CNT_W'(1)) == r_count);
    assign o_sts.shift_more = (r_addr <= r_count);

    // read pipeline tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
        r_rd_shift <= i_cmd.shift_rd;
        r_rd_idx   <= r_addr;
    end

    // read address pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_addr <= '0;
        end else if (i_cmd.pick) begin
            r_addr <= r_best_idx + CNT_W'(1);
        end else if (rd_en) begin
            r_addr <= r_addr + CNT_W'(1);
        end
    end

    // running minimum, strict less keeps the earliest arrival on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best_ok <= 1'b0;
        end else if (r_rd_vld && !r_rd_shift && (!r_best_ok || rd_len < r_best_len)) begin
            r_best_ok  <= 1'b1;
            r_best_idx <= r_rd_idx;
            r_best_id  <= rd_id;
            r_best_len <= rd_len;
        end
    end

    // waiting count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (arr_wr) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pick) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // per-tick flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dropped <= i_item.arrival_valid && full;
            r_picked  <= 1'b0;
        end else if (i_cmd.pick) begin
            r_picked <= 1'b1;
        end
    end

    // running task and one tick of execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_busy <= 1'b0;
            r_cur_id    <= '0;
            r_remain    <= '0;
        end else if (i_cmd.pick) begin
            r_task_busy <= 1'b1;
            r_cur_id    <= r_best_id;
            r_remain    <= r_best_len;
        end else if (i_cmd.run && r_task_busy) begin
            r_remain <= r_remain - LENGTH_BITS'(1);
            if (r_remain <= LENGTH_BITS'(1)) begin
                r_task_busy <= 1'b0;
            end
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.run;
        end
        if (i_cmd.run) begin
            r_out.running_valid   <= r_task_busy;
            r_out.running_id      <= r_task_busy ? r_cur_id : '0;
            r_out.picked_now      <= r_picked;
            r_out.arrival_dropped <= r_dropped;
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_vld;

endmodule

[rtl/core/sjn_ctrl.sv]
// ----------------------------------------------------------------------------
// sjn_ctrl
// Scheduler controller: sequences accept, minimum scan, pick, queue
// compaction and execution of one tick.
// ----------------------------------------------------------------------------
module sjn_ctrl
    import sjn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_PICK     = 3'd4;
    localparam logic [2:0] S_SHIFT    = 3'd5;
    localparam logic [2:0] S_RUN      = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_pick) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift_rd = 1'b1;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/core/shortest_job_next_scheduler_top.sv]
// Sequence: after start and a decide step, the result strobe is registered from
// the run step when no pick is made; on a pick, the n waiting tasks are first
// scanned (one RAM read per cycle), the shortest is picked and the m tasks queued
// behind it are moved up (one read and one write per cycle to close the gap).
// Throughput: a new start is taken in the strobe cycle; the receiver cannot stall.
// Reset: synchronous active-low; clears the queue count and running task.
// ----------------------------------------------------------------------------
// shortest_job_next_scheduler_top
// Non-preemptive shortest-job-next scheduler, one tick per start command.
// ----------------------------------------------------------------------------
module shortest_job_next_scheduler_top
    import sjn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output t_out o_result,
    output logic o_valid
);

    t_cmd cmd;
    t_sts sts;

    sjn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    sjn_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

    // a transfer always makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // the result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // the result only appears once the tick is finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    // a fresh pick always runs
    a_pick_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.picked_now) |-> o_result.running_valid)
        else $error("pick flagged without a running task");

endmodule
